// ===== sv/bmp_rle8_run_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// RLE8 run decoder assertion macros
// Clocked, reset-qualified property shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef BMP_RLE8_RUN_DECODER_ASSERT_SVH
`define BMP_RLE8_RUN_DECODER_ASSERT_SVH

// same-cycle implication
`define RLE8_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rle8 decoder check failed");

// next-cycle implication
`define RLE8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rle8 decoder check failed");

`endif

// ===== sv/rle8_pkg.sv =====
// ----------------------------------------------------------------------------
// RLE8 run decoder package
// Parse phases, escape codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rle8_pkg;

    typedef enum logic [2:0] {
        PH_COUNT   = 3'd0,
        PH_VALUE   = 3'd1,
        PH_ESCAPE  = 3'd2,
        PH_DX      = 3'd3,
        PH_DY      = 3'd4,
        PH_LITERAL = 3'd5,
        PH_PAD     = 3'd6
    } t_phase;

    // a zero count byte opens an escape
    localparam logic [7:0] ESCAPE_LEAD = 8'd0;

    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 15;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 2'd2;

endpackage

`default_nettype wire

// ===== sv/bmp_rle8_run_decoder.sv =====
// ----------------------------------------------------------------------------
// BMP RLE8 run decoder
// Parses an RLE8 byte stream and emits pixel runs in flipped screen space.
// ----------------------------------------------------------------------------
//  channel  | signals                                        | dir
//  ---------+------------------------------------------------+-----
//  in word  | i_valid, o_stall, i_code_byte, i_last_byte      | in
//  out word | o_valid, i_stall, o_screen_x/y, o_color_index,  | out
//           | o_run_length, o_image_done                      |
//  config   | i_cfg_we, i_cfg_index, i_cfg_wdata              | in
//
//  One word per cycle while the result register is not held by i_stall; a
//  word taken into the input register is decoded from there, and its result
//  is written into the result register, which then drives o_valid.
//  Parse state and the cursor update in the same cycle the word is decoded.
//  A held result stalls input only while a word waits in the input register.
//  Synchronous active-low reset clears parse state and loads register
//  defaults (height 1, origin 0, 0).
// ----------------------------------------------------------------------------
`default_nettype none

`include "bmp_rle8_run_decoder_assert.svh"

module bmp_rle8_run_decoder
    import rle8_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input words
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [7:0]           i_code_byte,
    input  wire logic                 i_last_byte,
    // result words
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [15:0]        o_screen_x,
    output logic signed [15:0]        o_screen_y,
    output logic [7:0]                o_color_index,
    output logic [7:0]                o_run_length,
    output logic                      o_image_done,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    // configuration registers
    logic [CFG_W-1:0] r_image_height;
    logic [CFG_W-1:0] r_origin_x;
    logic [CFG_W-1:0] r_origin_y;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parse state
    t_phase      r_phase, n_phase;
    logic [15:0] r_cursor_x, n_cursor_x;
    logic [15:0] r_cursor_y, n_cursor_y;
    logic [7:0]  r_held_count, n_held_count;
    logic [7:0]  r_literal_left, n_literal_left;
    logic        r_pad_pending, n_pad_pending;
    logic        r_finished, n_finished;

    // result register
    logic        r_out_valid;
    logic [15:0] r_out_x;
    logic [15:0] r_out_y;
    logic [7:0]  r_out_color;
    logic [7:0]  r_out_len;
    logic        r_out_done;

    // decode-stage results
    logic        w_fire;
    logic        w_emit;
    logic [7:0]  w_color;
    logic [7:0]  w_len;
    logic        w_done;
    logic [15:0] w_pos_x;
    logic [15:0] w_pos_y;
    logic [15:0] w_sx;
    logic [15:0] w_sy;
    logic [7:0]  w_lit_dec;

    assign w_fire  = r_in_valid && !(r_out_valid && i_stall);
    assign o_stall = r_in_valid && !w_fire;

    assign w_sx = w_pos_x + {1'b0, r_origin_x};
    assign w_sy = {1'b0, r_image_height} - 16'd1 - w_pos_y + {1'b0, r_origin_y};
    assign w_lit_dec = r_literal_left - 8'd1;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_height <= CFG_W'(1);
            r_origin_x     <= '0;
            r_origin_y     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata;
                REG_ORIGIN_X:     r_origin_x     <= i_cfg_wdata;
                REG_ORIGIN_Y:     r_origin_y     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_code_byte;
            r_in_last <= i_last_byte;
        end
    end

    // ---------------- next phase ----------------
    always_comb begin
        n_phase = r_phase;
        if (r_finished) begin
            n_phase = r_phase;
        end else begin
            case (r_phase)
                PH_COUNT:   n_phase = (r_in_byte == ESCAPE_LEAD) ? PH_ESCAPE : PH_VALUE;
                PH_VALUE:   n_phase = PH_COUNT;
                PH_ESCAPE: begin
                    if (r_in_byte == ESC_EOL || r_in_byte == ESC_EOB) begin
                        n_phase = PH_COUNT;
                    end else if (r_in_byte == ESC_DELTA) begin
                        n_phase = PH_DX;
                    end else begin
                        n_phase = PH_LITERAL;
                    end
                end
                PH_DX:      n_phase = PH_DY;
                PH_DY:      n_phase = PH_COUNT;
                PH_LITERAL: begin
                    if (w_lit_dec == 8'd0) begin
                        n_phase = r_pad_pending ? PH_PAD : PH_COUNT;
                    end
                end
                PH_PAD:     n_phase = PH_COUNT;
                default:    n_phase = PH_COUNT;
            endcase
        end
        if (r_in_last) begin
            n_phase = PH_COUNT;
        end
    end

    // ---------------- cursor, counters and result ----------------
    always_comb begin
        n_cursor_x     = r_cursor_x;
        n_cursor_y     = r_cursor_y;
        n_held_count   = r_held_count;
        n_literal_left = r_literal_left;
        n_pad_pending  = r_pad_pending;
        n_finished     = r_finished;
        w_emit         = 1'b0;
        w_color        = 8'd0;
        w_len          = 8'd0;
        w_done         = 1'b0;
        w_pos_x        = r_cursor_x;
        w_pos_y        = r_cursor_y;

        if (!r_finished) begin
            case (r_phase)
                PH_COUNT: begin
                    if (r_in_byte != ESCAPE_LEAD) begin
                        n_held_count = r_in_byte;
                    end
                end
                PH_VALUE: begin
                    w_emit       = 1'b1;
                    w_color      = r_in_byte;
                    w_len        = r_held_count;
                    w_done       = r_in_last;
                    n_cursor_x   = r_cursor_x + {8'd0, r_held_count};
                    n_held_count = 8'd0;
                end
                PH_ESCAPE: begin
                    if (r_in_byte == ESC_EOL) begin
                        n_cursor_y = r_cursor_y + 16'd1;
                        n_cursor_x = 16'd0;
                    end else if (r_in_byte == ESC_EOB) begin
                        w_emit     = 1'b1;
                        w_done     = 1'b1;
                        n_finished = 1'b1;
                    end else if (r_in_byte != ESC_DELTA) begin
                        n_literal_left = r_in_byte;
                        n_pad_pending  = r_in_byte[0];
                    end
                end
                PH_DX:   n_cursor_x = r_cursor_x + {8'd0, r_in_byte};
                PH_DY:   n_cursor_y = r_cursor_y + {8'd0, r_in_byte};
                PH_LITERAL: begin
                    w_emit         = 1'b1;
                    w_color        = r_in_byte;
                    w_len          = 8'd1;
                    w_done         = r_in_last;
                    n_cursor_x     = r_cursor_x + 16'd1;
                    n_literal_left = w_lit_dec;
                    if (w_lit_dec == 8'd0) begin
                        n_pad_pending = 1'b0;
                    end
                end
                default: begin
                end
            endcase

            // final byte reports done unless the image already ended, even with nothing
            // to draw, at the cursor this byte leaves behind
            if (r_in_last && !w_emit) begin
                w_emit  = 1'b1;
                w_done  = 1'b1;
                w_pos_x = n_cursor_x;
                w_pos_y = n_cursor_y;
            end
        end

        // final byte drops back to a clean parse
        if (r_in_last) begin
            n_cursor_x     = 16'd0;
            n_cursor_y     = 16'd0;
            n_held_count   = 8'd0;
            n_literal_left = 8'd0;
            n_pad_pending  = 1'b0;
            n_finished     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_COUNT;
            r_cursor_x     <= '0;
            r_cursor_y     <= '0;
            r_held_count   <= '0;
            r_literal_left <= '0;
            r_pad_pending  <= 1'b0;
            r_finished     <= 1'b0;
        end else if (w_fire) begin
            r_phase        <= n_phase;
            r_cursor_x     <= n_cursor_x;
            r_cursor_y     <= n_cursor_y;
            r_held_count   <= n_held_count;
            r_literal_left <= n_literal_left;
            r_pad_pending  <= n_pad_pending;
            r_finished     <= n_finished;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out_x     <= w_sx;
            r_out_y     <= w_sy;
            r_out_color <= w_color;
            r_out_len   <= w_len;
            r_out_done  <= w_done;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_screen_x    = signed'(r_out_x);
    assign o_screen_y    = signed'(r_out_y);
    assign o_color_index = r_out_color;
    assign o_run_length  = r_out_len;
    assign o_image_done  = r_out_done;

    // ---------------- assertions ----------------
    `RLE8_ASSERT_NOW(a_stall_only_on_full_out, i_clk, i_rst_n,
        o_stall, r_in_valid && r_out_valid && i_stall)
    `RLE8_ASSERT_NEXT(a_last_clears_parse, i_clk, i_rst_n,
        w_fire && r_in_last,
        r_phase == PH_COUNT && !r_finished && r_cursor_x == 16'd0 && r_cursor_y == 16'd0)
    `RLE8_ASSERT_NEXT(a_finished_is_silent, i_clk, i_rst_n,
        w_fire && r_finished, !r_out_valid)
    `RLE8_ASSERT_NEXT(a_value_gives_run, i_clk, i_rst_n,
        w_fire && !r_finished && r_phase == PH_VALUE,
        r_out_valid && r_out_len != 8'd0)
    `RLE8_ASSERT_NOW(a_literal_count_live, i_clk, i_rst_n,
        r_phase == PH_LITERAL, r_literal_left != 8'd0)

endmodule

`default_nettype wire

// ===== bench/bmp_rle8_run_checker.sv =====
// ----------------------------------------------------------------------------
// RLE8 run decoder checker
// Tracks the byte parse alongside the decoder and compares every run word
// it sends against the run predicted from the accepted code words.
// ----------------------------------------------------------------------------
module bmp_rle8_run_checker
    import rle8_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // code words into the decoder
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [7:0]           i_code_byte,
    input  logic                 i_last_byte,
    // run words out of the decoder
    input  logic                 i_run_valid,
    input  logic                 i_run_stall,
    input  logic signed [15:0]   i_screen_x,
    input  logic signed [15:0]   i_screen_y,
    input  logic [7:0]           i_color_index,
    input  logic [7:0]           i_run_length,
    input  logic                 i_image_done,
    // register writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_word_count,
    output int                   o_run_count,
    output int                   o_done_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic [7:0]         color_index;
        logic [7:0]         run_length;
        logic               image_done;
    } t_run;

    t_run expected_runs[$];

    logic [CFG_W-1:0] height;
    logic [CFG_W-1:0] org_x;
    logic [CFG_W-1:0] org_y;

    t_phase     phase;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic [7:0]  run_count;
    logic [7:0]  lit_left;
    logic        pad_after;
    logic        finished;

    // rows are stored bottom-up: flip against the height, then shift
    function automatic t_run flipped_run(input logic [7:0] color, input logic [7:0] len,
                                         input logic done);
        t_run r;
        r.screen_x    = cur_x + 16'(org_x);
        r.screen_y    = 16'(height) - 16'd1 - cur_y + 16'(org_y);
        r.color_index = color;
        r.run_length  = len;
        r.image_done  = done;
        return r;
    endfunction

    task automatic clear_parse();
        phase     = PH_COUNT;
        cur_x     = '0;
        cur_y     = '0;
        run_count = '0;
        lit_left  = '0;
        pad_after = 1'b0;
        finished  = 1'b0;
    endtask

    task automatic decode_word(input logic [7:0] b, input logic last);
        logic emitted;
        emitted = 1'b0;
        if (finished) begin
            // done already reported: a final word only restarts the parse
            if (last) clear_parse();
        end else begin
            case (phase)
                PH_COUNT: begin
                    if (b == ESCAPE_LEAD) begin
                        phase = PH_ESCAPE;
                    end else begin
                        run_count = b;
                        phase     = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    expected_runs.push_back(flipped_run(b, run_count, last));
                    emitted   = 1'b1;
                    cur_x     = cur_x + 16'(run_count);
                    run_count = '0;
                    phase     = PH_COUNT;
                end
                PH_ESCAPE: begin
                    if (b == ESC_EOL) begin
                        cur_y = cur_y + 16'd1;
                        cur_x = '0;
                        phase = PH_COUNT;
                    end else if (b == ESC_EOB) begin
                        expected_runs.push_back(flipped_run(8'd0, 8'd0, 1'b1));
                        emitted  = 1'b1;
                        finished = 1'b1;
                        phase    = PH_COUNT;
                    end else if (b == ESC_DELTA) begin
                        phase = PH_DX;
                    end else begin
                        lit_left  = b;
                        pad_after = b[0];
                        phase     = PH_LITERAL;
                    end
                end
                PH_DX: begin
                    cur_x = cur_x + 16'(b);
                    phase = PH_DY;
                end
                PH_DY: begin
                    cur_y = cur_y + 16'(b);
                    phase = PH_COUNT;
                end
                PH_LITERAL: begin
                    expected_runs.push_back(flipped_run(b, 8'd1, last));
                    emitted  = 1'b1;
                    cur_x    = cur_x + 16'd1;
                    lit_left = lit_left - 8'd1;
                    if (lit_left == 8'd0) begin
                        phase     = pad_after ? PH_PAD : PH_COUNT;
                        pad_after = 1'b0;
                    end
                end
                PH_PAD: begin
                    phase = PH_COUNT;
                end
                default: begin
                    phase = PH_COUNT;
                end
            endcase
            if (last) begin
                if (!emitted) expected_runs.push_back(flipped_run(8'd0, 8'd0, 1'b1));
                clear_parse();
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_run want;
        if (!i_rst_n) begin
            height = CFG_W'(1);
            org_x  = '0;
            org_y  = '0;
            clear_parse();
            expected_runs.delete();
            o_fail_count = 0;
            o_word_count = 0;
            o_run_count  = 0;
            o_done_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_HEIGHT: height = i_cfg_wdata;
                    REG_ORIGIN_X:     org_x  = i_cfg_wdata;
                    REG_ORIGIN_Y:     org_y  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                o_word_count++;
                decode_word(i_code_byte, i_last_byte);
            end
            if (i_run_valid && !i_run_stall) begin
                if (expected_runs.size() == 0) begin
                    $error("unexpected run word: x %0d y %0d color %0d length %0d done %0b",
                           i_screen_x, i_screen_y, i_color_index, i_run_length,
                           i_image_done);
                    o_fail_count++;
                end else begin
                    want = expected_runs.pop_front();
                    o_run_count++;
                    if (want.image_done) o_done_count++;
                    if (i_screen_x !== want.screen_x) begin
                        $error("screen_x: expected %0d, got %0d", want.screen_x, i_screen_x);
                        o_fail_count++;
                    end
                    if (i_screen_y !== want.screen_y) begin
                        $error("screen_y: expected %0d, got %0d", want.screen_y, i_screen_y);
                        o_fail_count++;
                    end
                    if (i_color_index !== want.color_index) begin
                        $error("color_index: expected %0d, got %0d", want.color_index,
                               i_color_index);
                        o_fail_count++;
                    end
                    if (i_run_length !== want.run_length) begin
                        $error("run_length: expected %0d, got %0d", want.run_length,
                               i_run_length);
                        o_fail_count++;
                    end
                    if (i_image_done !== want.image_done) begin
                        $error("image_done: expected %0b, got %0b", want.image_done,
                               i_image_done);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_runs.size();
    end

endmodule

// ===== bench/bmp_rle8_run_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// RLE8 run decoder testbench
// Feeds directed and random RLE8 byte streams under several register settings
// and idle patterns; a side checker predicts and compares every run word.
// ----------------------------------------------------------------------------
module bmp_rle8_run_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rle8_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_code_byte = '0;
    logic                 i_last_byte = 1'b0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic signed [15:0]   o_screen_x;
    logic signed [15:0]   o_screen_y;
    logic [7:0]           o_color_index;
    logic [7:0]           o_run_length;
    logic                 o_image_done;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_IMAGE_HEIGHT;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int last_permille = 0;
    int cycle_count   = 0;

    int fail_count;
    int pending_runs;
    int word_count;
    int run_count;
    int done_count;

    bmp_rle8_run_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_code_byte   (i_code_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_screen_x    (o_screen_x),
        .o_screen_y    (o_screen_y),
        .o_color_index (o_color_index),
        .o_run_length  (o_run_length),
        .o_image_done  (o_image_done),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    bmp_rle8_run_checker u_run_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_code_byte   (i_code_byte),
        .i_last_byte   (i_last_byte),
        .i_run_valid   (o_valid),
        .i_run_stall   (i_stall),
        .i_screen_x    (o_screen_x),
        .i_screen_y    (o_screen_y),
        .i_color_index (o_color_index),
        .i_run_length  (o_run_length),
        .i_image_done  (o_image_done),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending_runs),
        .o_word_count  (word_count),
        .o_run_count   (run_count),
        .o_done_count  (done_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic pick_last();
        return $urandom_range(999) < last_permille;
    endfunction

    // called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with valid still high
    task automatic send_word(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic program_config(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] ox,
                                  input logic [CFG_W-1:0] oy);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_IMAGE_HEIGHT;
        i_cfg_wdata <= h;
        @(negedge i_clk);
        i_cfg_index <= REG_ORIGIN_X;
        i_cfg_wdata <= ox;
        @(negedge i_clk);
        i_cfg_index <= REG_ORIGIN_Y;
        i_cfg_wdata <= oy;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // drop valid, wait out the predicted runs, then let the pipeline empty
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_runs != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_directed();
        send_word(8'hFF, 1'b0);          // longest encoded run
        send_word(8'h55, 1'b0);
        send_word(8'h01, 1'b0);          // shortest run, color zero
        send_word(8'h00, 1'b0);
        send_word(ESCAPE_LEAD, 1'b0);    // end of line
        send_word(ESC_EOL, 1'b0);
        send_word(ESCAPE_LEAD, 1'b0);    // largest cursor move
        send_word(ESC_DELTA, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(ESCAPE_LEAD, 1'b0);    // odd literal, pad skipped
        send_word(8'h03, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'hEE, 1'b0);
        send_word(8'h05, 1'b1);          // stream cut after a count
        send_word(8'h02, 1'b0);          // final word completes a run
        send_word(8'hAB, 1'b1);
        send_word(ESCAPE_LEAD, 1'b0);    // end marker, then ignored words
        send_word(ESC_EOB, 1'b0);
        send_word(8'h33, 1'b0);
        send_word(8'h44, 1'b1);
        send_word(ESCAPE_LEAD, 1'b0);    // final word inside a literal
        send_word(8'h04, 1'b0);
        send_word(8'hC3, 1'b1);
    endtask

    // mostly well-formed sequences with random content; the sweep variant
    // piles up large cursor moves so both cursors wrap
    task automatic send_random_stream(input int n_words, input bit wrap_sweep);
        int sent;
        int kind;
        int cnt;
        sent = 0;
        while (sent < n_words) begin
            kind = $urandom_range(99);
            if (wrap_sweep && kind < 90) begin
                send_word(ESCAPE_LEAD, 1'b0);
                send_word(ESC_DELTA, 1'b0);
                send_word(8'($urandom_range(224, 255)), 1'b0);
                send_word(8'($urandom_range(224, 255)), 1'b0);
                sent += 4;
            end else if (wrap_sweep || kind < 40) begin
                cnt = ($urandom_range(9) < 7) ? $urandom_range(1, 16) : $urandom_range(1, 255);
                send_word(8'(cnt), pick_last());
                send_word(8'($urandom), pick_last());
                sent += 2;
            end else if (kind < 50) begin
                send_word(ESCAPE_LEAD, pick_last());
                send_word(ESC_EOL, pick_last());
                sent += 2;
            end else if (kind < 62) begin
                send_word(ESCAPE_LEAD, pick_last());
                send_word(ESC_DELTA, pick_last());
                send_word(8'($urandom), pick_last());
                send_word(8'($urandom), pick_last());
                sent += 4;
            end else if (kind < 82) begin
                cnt = ($urandom_range(9) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
                send_word(ESCAPE_LEAD, pick_last());
                send_word(8'(cnt), pick_last());
                repeat (cnt) send_word(8'($urandom), pick_last());
                if (cnt % 2 == 1) send_word(8'($urandom), pick_last());
                sent += 2 + cnt + cnt % 2;
            end else if (kind < 88) begin
                cnt = $urandom_range(3);
                send_word(ESCAPE_LEAD, pick_last());
                send_word(ESC_EOB, pick_last());
                repeat (cnt) send_word(8'($urandom), 1'b0);
                send_word(8'($urandom), 1'b1);
                sent += 3 + cnt;
            end else if (kind < 93) begin
                send_word(8'($urandom), 1'b1);
                sent += 1;
            end else begin
                send_word(8'($urandom), pick_last());
                sent += 1;
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] ox,
                             input logic [CFG_W-1:0] oy, input int idle_pct,
                             input int stall, input int n_words, input bit wrap_sweep);
        drain();
        program_config(h, ox, oy);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        last_permille = wrap_sweep ? 0 : 15;
        send_random_stream(n_words, wrap_sweep);
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        program_config(CFG_W'(1), '0, '0);
        send_directed();

        run_phase(CFG_W'(32767), CFG_W'(32767), CFG_W'(32767), 71, 0, 170, 1'b0);
        run_phase('0, '0, CFG_W'(32767), 0, 71, 170, 1'b0);
        run_phase(CFG_W'($urandom_range(1, 32767)), CFG_W'($urandom),
                  CFG_W'($urandom), 8, 8, 1300, 1'b1);
        run_phase(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom),
                  CFG_W'($urandom), 0, 0, 170, 1'b0);
        drain();
        repeat (10) @(negedge i_clk);

        $display("Decoded %0d code words into %0d checked runs, %0d of them image ends.",
                 word_count, run_count, done_count);
        $display("Heights 0, 1 and 32767, origin extremes, cursor wrap, idle and stall mixes.");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
